// ----- rtl/sat_trail_pkg.sv -----
// Shared types, field widths and codes of the assignment trail.
`default_nettype none

package sat_trail_pkg;

  localparam int FIELD_W      = 11;
  localparam int CMD_W        = 3;
  localparam int ERR_W        = 3;
  localparam int MAX_VARS_DEF = 1024;

  localparam logic [CMD_W-1:0] CMD_ASSIGN   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DECIDE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BT_LEVEL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BT_LIT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK           = 3'd0;
  localparam logic [ERR_W-1:0] ERR_INVALID_VAR  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NOT_ASSIGNED = 3'd2;
  localparam logic [ERR_W-1:0] ERR_REASSIGN     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_LEVEL        = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] var_id;
    logic               polarity;
    logic [FIELD_W-1:0] other_var;
    logic [FIELD_W-1:0] target_level;
  } sat_trail_in_t;

  typedef struct packed {
    logic [ERR_W-1:0]   error;
    logic               assigned;
    logic               lit_true;
    logic [FIELD_W-1:0] var_level;
    logic               decided;
    logic               is_before;
    logic [FIELD_W-1:0] current_level;
    logic [FIELD_W-1:0] unassigned_count;
    logic [FIELD_W-1:0] last_var;
    logic               last_value;
    logic [FIELD_W-1:0] last_decision_var;
  } sat_trail_out_t;

  // Read and write enables of the three memories.
  typedef struct packed {
    logic trail_we;
    logic trail_re_a;
    logic trail_re_b;
    logic pmap_we;
    logic pmap_re_a;
    logic pmap_re_b;
    logic stk_we;
    logic stk_re_a;
    logic stk_re_b;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/sat_trail_mem.sv -----
// Trail, position map and decision stack memories with registered read ports.
`default_nettype none

module sat_trail_mem #(
  parameter int MAX_VARS = sat_trail_pkg::MAX_VARS_DEF
) (
  input  logic                               clk,
  input  sat_trail_pkg::mem_ctl_t            ctl,
  input  logic [$clog2(MAX_VARS)-1:0]        trail_waddr,
  input  logic [sat_trail_pkg::FIELD_W-1:0]  trail_wvar,
  input  logic                               trail_wval,
  input  logic [$clog2(MAX_VARS+1)-1:0]      trail_wlvl,
  input  logic [$clog2(MAX_VARS)-1:0]        trail_raddr_a,
  input  logic [$clog2(MAX_VARS)-1:0]        trail_raddr_b,
  output logic [sat_trail_pkg::FIELD_W-1:0]  trail_var_a,
  output logic                               trail_val_a,
  output logic [$clog2(MAX_VARS+1)-1:0]      trail_lvl_a,
  output logic [sat_trail_pkg::FIELD_W-1:0]  trail_var_b,
  input  logic [$clog2(MAX_VARS)-1:0]        pmap_waddr,
  input  logic [$clog2(MAX_VARS)-1:0]        pmap_wdata,
  input  logic [$clog2(MAX_VARS)-1:0]        pmap_raddr_a,
  input  logic [$clog2(MAX_VARS)-1:0]        pmap_raddr_b,
  output logic [$clog2(MAX_VARS)-1:0]        pmap_rd_a,
  output logic [$clog2(MAX_VARS)-1:0]        pmap_rd_b,
  input  logic [$clog2(MAX_VARS)-1:0]        stk_waddr,
  input  logic [sat_trail_pkg::FIELD_W-1:0]  stk_wdata,
  input  logic [$clog2(MAX_VARS)-1:0]        stk_raddr_a,
  input  logic [$clog2(MAX_VARS)-1:0]        stk_raddr_b,
  output logic [sat_trail_pkg::FIELD_W-1:0]  stk_rd_a,
  output logic [sat_trail_pkg::FIELD_W-1:0]  stk_rd_b
);
  import sat_trail_pkg::*;

  localparam int PW = $clog2(MAX_VARS);
  localparam int CW = $clog2(MAX_VARS + 1);
  localparam int TW = FIELD_W + 1 + CW;

  // A trail entry is packed as variable, value, level from the top bit down.
  logic [TW-1:0]      trail_mem_r [MAX_VARS];
  logic [PW-1:0]      pmap_mem_r  [MAX_VARS];
  logic [FIELD_W-1:0] stk_mem_r   [MAX_VARS];

  logic [TW-1:0]      trail_rd_a_r;
  logic [FIELD_W-1:0] trail_rd_b_r;
  logic [PW-1:0]      pmap_rd_a_r;
  logic [PW-1:0]      pmap_rd_b_r;
  logic [FIELD_W-1:0] stk_rd_a_r;
  logic [FIELD_W-1:0] stk_rd_b_r;

  always_ff @(posedge clk) begin
    if (ctl.trail_we) begin
      trail_mem_r[trail_waddr] <= {trail_wvar, trail_wval, trail_wlvl};
    end
    if (ctl.trail_re_a) begin
      trail_rd_a_r <= trail_mem_r[trail_raddr_a];
    end
    if (ctl.trail_re_b) begin
      trail_rd_b_r <= trail_mem_r[trail_raddr_b][TW-1 -: FIELD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pmap_we) begin
      pmap_mem_r[pmap_waddr] <= pmap_wdata;
    end
    if (ctl.pmap_re_a) begin
      pmap_rd_a_r <= pmap_mem_r[pmap_raddr_a];
    end
    if (ctl.pmap_re_b) begin
      pmap_rd_b_r <= pmap_mem_r[pmap_raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.stk_we) begin
      stk_mem_r[stk_waddr] <= stk_wdata;
    end
    if (ctl.stk_re_a) begin
      stk_rd_a_r <= stk_mem_r[stk_raddr_a];
    end
    if (ctl.stk_re_b) begin
      stk_rd_b_r <= stk_mem_r[stk_raddr_b];
    end
  end

  assign trail_var_a = trail_rd_a_r[TW-1 -: FIELD_W];
  assign trail_val_a = trail_rd_a_r[CW];
  assign trail_lvl_a = trail_rd_a_r[CW-1:0];
  assign trail_var_b = trail_rd_b_r;
  assign pmap_rd_a   = pmap_rd_a_r;
  assign pmap_rd_b   = pmap_rd_b_r;
  assign stk_rd_a    = stk_rd_a_r;
  assign stk_rd_b    = stk_rd_b_r;

endmodule

`default_nettype wire

// ----- rtl/sat_assignment_trail.sv -----
// Top level of the assignment trail: command sequencer, counters and result register.
// Each request occupies the block from its acceptance to the acceptance of the
// next one, and stays longer only while the previous result is still stalled
// in the output register. The occupancy is set by the chain of dependent
// registered memory reads: the position map, then the trail entry it points to,
// once before the update is written and once after it, and finally the decision
// stack at the level of that entry. The memories need no clearing pass after
// reset; a position map entry is trusted only when the trail entry it points to
// lies below the trail length and holds the same variable.
`default_nettype none

module sat_assignment_trail #(
  parameter int MAX_VARS = sat_trail_pkg::MAX_VARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sat_trail_pkg::sat_trail_in_t      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sat_trail_pkg::sat_trail_out_t     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sat_trail_pkg::FIELD_W-1:0] cfg_data
);
  import sat_trail_pkg::*;

  localparam int PW = $clog2(MAX_VARS);
  localparam int CW = $clog2(MAX_VARS + 1);
  localparam int EW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;
  localparam logic [EW-1:0] MAXV = EW'(MAX_VARS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FETCH  = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_QMAP   = 3'd3;
  localparam logic [2:0] ST_QTRAIL = 3'd4;
  localparam logic [2:0] ST_QSTK   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      trail_len_r, len_nxt;
  logic [CW-1:0]      dec_cnt_r, dc_nxt;
  logic [FIELD_W-1:0] num_vars_r;
  logic               out_valid_r;
  sat_trail_in_t      req_r;
  logic [ERR_W-1:0]   err_r, err_nxt;
  logic [FIELD_W-1:0] top_var_r;
  logic               top_val_r;
  sat_trail_out_t     out_data_r, res;

  logic req_take, out_free;

  mem_ctl_t           ctl;
  logic [PW-1:0]      trail_waddr, trail_raddr_a, trail_raddr_b;
  logic [FIELD_W-1:0] trail_wvar;
  logic               trail_wval;
  logic [CW-1:0]      trail_wlvl;
  logic [FIELD_W-1:0] trail_var_a, trail_var_b;
  logic               trail_val_a;
  logic [CW-1:0]      trail_lvl_a;
  logic [PW-1:0]      pmap_waddr, pmap_wdata, pmap_raddr_a, pmap_raddr_b;
  logic [PW-1:0]      pmap_rd_a, pmap_rd_b;
  logic [PW-1:0]      stk_waddr, stk_raddr_a, stk_raddr_b;
  logic [FIELD_W-1:0] stk_wdata, stk_rd_a, stk_rd_b;

  logic [EW-1:0] nv_ext, eff_vars, v_ext, ov_ext, len_ext, dc_ext;
  logic [EW-1:0] pv_ext, po_ext, lvl_ext, una_ext;
  logic          vld_v, vld_o, asg_v, asg_o, is_top;
  logic          trail_push, trail_ovw, stk_push;
  logic [CW-1:0] q_lvl;

  sat_trail_mem #(
    .MAX_VARS(MAX_VARS)
  ) u_mem (
    .clk          (clk),
    .ctl          (ctl),
    .trail_waddr  (trail_waddr),
    .trail_wvar   (trail_wvar),
    .trail_wval   (trail_wval),
    .trail_wlvl   (trail_wlvl),
    .trail_raddr_a(trail_raddr_a),
    .trail_raddr_b(trail_raddr_b),
    .trail_var_a  (trail_var_a),
    .trail_val_a  (trail_val_a),
    .trail_lvl_a  (trail_lvl_a),
    .trail_var_b  (trail_var_b),
    .pmap_waddr   (pmap_waddr),
    .pmap_wdata   (pmap_wdata),
    .pmap_raddr_a (pmap_raddr_a),
    .pmap_raddr_b (pmap_raddr_b),
    .pmap_rd_a    (pmap_rd_a),
    .pmap_rd_b    (pmap_rd_b),
    .stk_waddr    (stk_waddr),
    .stk_wdata    (stk_wdata),
    .stk_raddr_a  (stk_raddr_a),
    .stk_raddr_b  (stk_raddr_b),
    .stk_rd_a     (stk_rd_a),
    .stk_rd_b     (stk_rd_b)
  );

  assign req_take  = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Common comparisons. Port A of the position map and of the trail holds the
  // requested variable's entry both before and after the update.
  always_comb begin
    nv_ext   = EW'(num_vars_r);
    eff_vars = (nv_ext > MAXV) ? MAXV : nv_ext;
    v_ext    = EW'(req_r.var_id);
    ov_ext   = EW'(req_r.other_var);
    len_ext  = EW'(trail_len_r);
    dc_ext   = EW'(dec_cnt_r);
    pv_ext   = EW'(pmap_rd_a);
    po_ext   = EW'(pmap_rd_b);
    lvl_ext  = EW'(trail_lvl_a);
    vld_v    = (v_ext != '0) && (v_ext <= eff_vars);
    vld_o    = (ov_ext != '0) && (ov_ext <= eff_vars);
    asg_v    = vld_v && (pv_ext < len_ext) && (trail_var_a == req_r.var_id);
    asg_o    = vld_o && (po_ext < len_ext) && (trail_var_b == req_r.other_var);
    is_top   = (pv_ext + EW'(1)) == len_ext;
  end

  // Command evaluation against the state before the update.
  always_comb begin
    len_nxt    = trail_len_r;
    dc_nxt     = dec_cnt_r;
    err_nxt    = ERR_OK;
    trail_push = 1'b0;
    trail_ovw  = 1'b0;
    stk_push   = 1'b0;
    case (req_r.cmd)
      CMD_ASSIGN, CMD_DECIDE: begin
        if (!vld_v) begin
          err_nxt = ERR_INVALID_VAR;
        end else if (asg_v && !is_top) begin
          err_nxt = ERR_REASSIGN;
        end else if ((req_r.cmd == CMD_DECIDE) && (dc_ext >= MAXV)) begin
          err_nxt = ERR_LEVEL;
        end else if (!asg_v && (len_ext >= MAXV)) begin
          err_nxt = ERR_LEVEL;
        end else begin
          if (req_r.cmd == CMD_DECIDE) begin
            stk_push = 1'b1;
            dc_nxt   = dec_cnt_r + CW'(1);
          end
          if (asg_v) begin
            trail_ovw = 1'b1;
          end else begin
            trail_push = 1'b1;
            len_nxt    = trail_len_r + CW'(1);
          end
        end
      end
      CMD_BT_LEVEL: begin
        if (EW'(req_r.target_level) > dc_ext) begin
          err_nxt = ERR_LEVEL;
        end else if (EW'(req_r.target_level) < dc_ext) begin
          if ((EW'(stk_rd_a) <= MAXV) && (po_ext < len_ext)) begin
            len_nxt = CW'(pmap_rd_b);
          end
          dc_nxt = CW'(req_r.target_level);
        end
      end
      CMD_BT_LIT: begin
        if (!vld_v) begin
          err_nxt = ERR_INVALID_VAR;
        end else if (!asg_v) begin
          err_nxt = ERR_NOT_ASSIGNED;
        end else begin
          len_nxt = CW'(pmap_rd_a);
          if (lvl_ext < dc_ext) begin
            dc_nxt = trail_lvl_a;
          end
        end
      end
      default: begin
        if (!vld_v) begin
          err_nxt = ERR_INVALID_VAR;
        end
      end
    endcase
  end

  // Write data. An overwrite keeps the top entry's variable and level.
  always_comb begin
    trail_waddr = trail_push ? trail_len_r[PW-1:0] : pmap_rd_a;
    trail_wvar  = trail_push ? req_r.var_id : trail_var_a;
    trail_wval  = req_r.polarity;
    trail_wlvl  = trail_lvl_a;
    if (trail_push) begin
      trail_wlvl = (req_r.cmd == CMD_DECIDE) ? (dec_cnt_r + CW'(1)) : dec_cnt_r;
    end
    pmap_waddr = PW'(v_ext - EW'(1));
    pmap_wdata = trail_len_r[PW-1:0];
    stk_waddr  = dec_cnt_r[PW-1:0];
    stk_wdata  = req_r.var_id;
  end

  // Memory read addressing per step of the sequence.
  always_comb begin
    ctl           = '0;
    trail_raddr_a = '0;
    trail_raddr_b = '0;
    pmap_raddr_a  = '0;
    pmap_raddr_b  = '0;
    stk_raddr_a   = '0;
    stk_raddr_b   = '0;
    case (state_r)
      ST_IDLE: begin
        if (req_take) begin
          ctl.pmap_re_a = 1'b1;
          pmap_raddr_a  = PW'(EW'(in_data.var_id) - EW'(1));
          ctl.stk_re_a  = 1'b1;
          stk_raddr_a   = PW'(in_data.target_level);
        end
      end
      ST_FETCH: begin
        ctl.trail_re_a = 1'b1;
        trail_raddr_a  = pmap_rd_a;
        ctl.pmap_re_b  = 1'b1;
        pmap_raddr_b   = PW'(EW'(stk_rd_a) - EW'(1));
      end
      ST_EXEC: begin
        ctl.trail_we = trail_push || trail_ovw;
        ctl.pmap_we  = trail_push;
        ctl.stk_we   = stk_push;
      end
      ST_QMAP: begin
        ctl.pmap_re_a  = 1'b1;
        pmap_raddr_a   = PW'(v_ext - EW'(1));
        ctl.pmap_re_b  = 1'b1;
        pmap_raddr_b   = PW'(ov_ext - EW'(1));
        ctl.trail_re_a = 1'b1;
        trail_raddr_a  = PW'(len_ext - EW'(1));
        ctl.stk_re_b   = 1'b1;
        stk_raddr_b    = PW'(dc_ext - EW'(1));
      end
      ST_QTRAIL: begin
        ctl.trail_re_a = 1'b1;
        trail_raddr_a  = pmap_rd_a;
        ctl.trail_re_b = 1'b1;
        trail_raddr_b  = pmap_rd_b;
      end
      ST_QSTK: begin
        ctl.stk_re_a = 1'b1;
        stk_raddr_a  = PW'(lvl_ext - EW'(1));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (req_take) state_nxt = ST_FETCH;
      ST_FETCH:  state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = ST_QMAP;
      ST_QMAP:   state_nxt = ST_QTRAIL;
      ST_QTRAIL: state_nxt = ST_QSTK;
      ST_QSTK:   state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Result assembled from the state after the update.
  always_comb begin
    q_lvl   = asg_v ? trail_lvl_a : '0;
    una_ext = (eff_vars > len_ext) ? (eff_vars - len_ext) : '0;
    res.error     = err_r;
    res.assigned  = asg_v;
    res.lit_true  = asg_v && (trail_val_a == req_r.polarity);
    res.var_level = FIELD_W'(q_lvl);
    res.decided   = asg_v && (lvl_ext != '0) && (lvl_ext <= dc_ext)
                    && (stk_rd_a == req_r.var_id);
    res.is_before = asg_v && asg_o && (req_r.other_var != req_r.var_id)
                    && (pmap_rd_a < pmap_rd_b);
    res.current_level     = FIELD_W'(dec_cnt_r);
    res.unassigned_count  = FIELD_W'(una_ext);
    res.last_var          = (trail_len_r != '0) ? top_var_r : '0;
    res.last_value        = (trail_len_r != '0) && top_val_r;
    res.last_decision_var = (dec_cnt_r != '0) ? stk_rd_b : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      trail_len_r <= '0;
      dec_cnt_r   <= '0;
      num_vars_r  <= FIELD_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        num_vars_r <= cfg_data;
      end
      if (state_r == ST_EXEC) begin
        trail_len_r <= len_nxt;
        dec_cnt_r   <= dc_nxt;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      req_r <= in_data;
    end
    if (state_r == ST_EXEC) begin
      err_r <= err_nxt;
    end
    // The top trail entry arrives on port A before that port is reused.
    if (state_r == ST_QTRAIL) begin
      top_var_r <= trail_var_a;
      top_val_r <= trail_val_a;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sat_trail_chk.sv -----
// Port-level checker of the assignment trail and its binding to the top level.
`default_nettype none

module sat_trail_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input sat_trail_pkg::sat_trail_in_t      in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input sat_trail_pkg::sat_trail_out_t     out_data,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [sat_trail_pkg::FIELD_W-1:0] cfg_data
);
  import sat_trail_pkg::*;

  // A stalled result must be held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or was dropped");

  // Only one request is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a request");

  // A new result is only produced by a busy block.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

  // An invalid variable never reports any assignment status.
  a_invalid_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error == ERR_INVALID_VAR)
      |-> !out_data.assigned && !out_data.lit_true && !out_data.decided
          && !out_data.is_before && (out_data.var_level == '0))
    else $error("invalid variable reported with status");

endmodule

bind sat_assignment_trail sat_trail_chk u_sat_trail_chk (.*);

`default_nettype wire
